/* rtl/core/tra_pkg.sv */
// Package for the tile rectangle first-fit allocator: field widths, codes,
// beat structs and the control structs shared by the core modules.
// No dependencies.
package tra_pkg;

    // Default grid capacity
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    // Field widths
    localparam int DIM_W   = 6;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 11;
    localparam int AREA_W  = 2 * DIM_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [DIM_W-1:0]   GRID_COLS_RST = 6'd32;
    localparam logic [DIM_W-1:0]   GRID_ROWS_RST = 6'd32;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_GRID_COLS = 1'b0,
        REG_GRID_ROWS = 1'b1
    } reg_idx_t;

    // Request beat
    typedef struct packed {
        cmd_t             cmd;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [POS_W-1:0] free_col;
        logic [POS_W-1:0] free_row;
    } req_t;

    // Result beat
    typedef struct packed {
        logic               success;
        logic [POS_W-1:0]   place_col;
        logic [POS_W-1:0]   place_row;
        logic [COUNT_W-1:0] tiles_in_use;
    } rsp_t;

    // Controller to column lanes
    typedef struct packed {
        logic clear;
        logic load;
    } lane_ctrl_t;

    // Column lanes to controller
    typedef struct packed {
        logic valid;
        logic hit;
    } lane_stat_t;

endpackage

/* rtl/core/tile_rectangle_first_fit_allocator.sv */
// Tile rectangle first-fit allocator: one item at a time, busy while working.
// Free: the result strobe follows the h rows read,
// modified and written back through the occupancy RAM port.
// Allocate: one row per cycle is streamed
// through the column lanes, then h rows are marked. Results cannot be stalled.
// Reset: all tiles read free at once through per-row valid flags, no sweep.
// Depends on tra_pkg, tra_ram, tra_lanes.
module tile_rectangle_first_fit_allocator #(
    parameter int MAX_COLS = tra_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tra_pkg::MAX_ROWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tra_pkg::req_t             req,
    output logic                      done,
    output tra_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  tra_pkg::reg_idx_t         cfg_idx,
    input  logic [tra_pkg::DIM_W-1:0] cfg_wdata
);

    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int RN_W = $clog2(MAX_ROWS + 1);
    localparam int CA_W = $clog2(MAX_COLS);
    localparam int CN_W = $clog2(MAX_COLS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PLAN = 4'b0010,
        S_SCAN = 4'b0100,
        S_MARK = 4'b1000
    } state_t;

    state_t                      state_reg,  state_next;
    tra_pkg::req_t               req_reg,    req_next;
    logic [RN_W-1:0]             ptr_reg,    ptr_next;
    logic [RN_W-1:0]             end_reg,    end_next;
    logic [CN_W-1:0]             lo_reg,     lo_next;
    logic [CN_W-1:0]             hi_reg,     hi_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [RA_W-1:0]             rd_addr_reg, rd_addr_next;
    logic [CA_W-1:0]             pc_reg,     pc_next;
    logic [RA_W-1:0]             pr_reg,     pr_next;
    logic                        done_reg,   done_next;
    tra_pkg::rsp_t               rsp_reg,    rsp_next;
    logic [tra_pkg::COUNT_W-1:0] count_reg,  count_next;
    logic [tra_pkg::DIM_W-1:0]   grid_cols_reg;
    logic [tra_pkg::DIM_W-1:0]   grid_rows_reg;
    logic                        row_vld_reg [MAX_ROWS];

    logic                        accept;
    logic [CN_W-1:0]             cols;
    logic [RN_W-1:0]             rows;
    logic [tra_pkg::AREA_W-1:0]  area;
    logic                        alloc_ok;
    logic                        free_ok;
    logic [RN_W-1:0]             free_end;
    logic [CN_W-1:0]             free_ce;
    logic [RN_W-1:0]             found_row;
    logic [tra_pkg::AREA_W:0]    count_sum;
    logic [tra_pkg::COUNT_W-1:0] count_upd;
    logic                        finish;
    logic                        fin_ok;

    logic                        ram_we;
    logic [RA_W-1:0]             ram_waddr;
    logic [MAX_COLS-1:0]         ram_wdata;
    logic                        ram_re;
    logic [RA_W-1:0]             ram_raddr;
    logic [MAX_COLS-1:0]         ram_rdata;
    logic [MAX_COLS-1:0]         row_eff;
    logic [MAX_COLS-1:0]         mark_mask;

    tra_pkg::lane_ctrl_t         lane_ctrl;
    tra_pkg::lane_stat_t         lane_stat;
    logic [CA_W-1:0]             lane_col;
    logic [RA_W-1:0]             lane_tag;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // Clamp the configured grid to the storage size
    always_comb
    begin
        if (int'(grid_cols_reg) > MAX_COLS)
        begin
            cols = CN_W'(MAX_COLS);
        end
        else
        begin
            cols = CN_W'(grid_cols_reg);
        end
        if (int'(grid_rows_reg) > MAX_ROWS)
        begin
            rows = RN_W'(MAX_ROWS);
        end
        else
        begin
            rows = RN_W'(grid_rows_reg);
        end
    end

    // Decode the held request
    always_comb
    begin
        area     = tra_pkg::AREA_W'(req_reg.rect_width)
                   * tra_pkg::AREA_W'(req_reg.rect_height);
        alloc_ok = (req_reg.rect_width != '0) && (req_reg.rect_height != '0)
                   && (int'(req_reg.rect_width) <= int'(cols))
                   && (int'(req_reg.rect_height) <= int'(rows));
        free_ok  = (req_reg.rect_width != '0) && (req_reg.rect_height != '0)
                   && (int'(req_reg.free_col) < int'(cols))
                   && (int'(req_reg.free_row) < int'(rows));
        if (int'(req_reg.free_row) + int'(req_reg.rect_height) > int'(rows))
        begin
            free_end = rows;
        end
        else
        begin
            free_end = RN_W'(int'(req_reg.free_row) + int'(req_reg.rect_height));
        end
        if (int'(req_reg.free_col) + int'(req_reg.rect_width) > int'(cols))
        begin
            free_ce = cols;
        end
        else
        begin
            free_ce = CN_W'(int'(req_reg.free_col) + int'(req_reg.rect_width));
        end
        found_row = RN_W'(int'(lane_tag) - int'(req_reg.rect_height) + 1);
    end

    // Saturating count update for the finishing item
    always_comb
    begin
        count_sum = (tra_pkg::AREA_W + 1)'(count_reg) + (tra_pkg::AREA_W + 1)'(area);
        if (req_reg.cmd == tra_pkg::CMD_FREE)
        begin
            if (int'(count_reg) > int'(area))
            begin
                count_upd = count_reg - tra_pkg::COUNT_W'(area);
            end
            else
            begin
                count_upd = '0;
            end
        end
        else if (count_sum > (tra_pkg::AREA_W + 1)'(tra_pkg::COUNT_MAX))
        begin
            count_upd = tra_pkg::COUNT_MAX;
        end
        else
        begin
            count_upd = tra_pkg::COUNT_W'(count_sum);
        end
    end

    // Column span of the rectangle being marked or cleared
    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
        begin
            mark_mask[j] = (j >= int'(lo_reg)) && (j < int'(hi_reg));
        end
    end

    // Rows never written read as free
    assign row_eff = row_vld_reg[rd_addr_reg] ? ram_rdata : '0;

    // Sequencer: plan, scan rows through the lanes (allocate only), then read-modify-write
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = rd_addr_reg;
        pc_next      = pc_reg;
        pr_next      = pr_reg;
        finish       = 1'b0;
        fin_ok       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = ptr_reg[RA_W-1:0];
        ram_we       = 1'b0;
        ram_waddr    = rd_addr_reg;
        if (req_reg.cmd == tra_pkg::CMD_FREE)
        begin
            ram_wdata = row_eff & ~mark_mask;
        end
        else
        begin
            ram_wdata = row_eff | mark_mask;
        end
        lane_ctrl.clear = 1'b0;
        lane_ctrl.load  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                pc_next = '0;
                pr_next = '0;
                if (req_reg.cmd == tra_pkg::CMD_ALLOC)
                begin
                    if (alloc_ok)
                    begin
                        ptr_next        = '0;
                        lane_ctrl.clear = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (free_ok)
                begin
                    ptr_next   = RN_W'(req_reg.free_row);
                    end_next   = free_end;
                    lo_next    = CN_W'(req_reg.free_col);
                    hi_next    = free_ce;
                    state_next = S_MARK;
                end
                else
                begin
                    finish = 1'b1;
                    fin_ok = 1'b1;
                end
            end
            S_SCAN:
            begin
                lane_ctrl.load = rd_pend_reg;
                if (ptr_reg < rows)
                begin
                    ram_re       = 1'b1;
                    ptr_next     = ptr_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr_next = ptr_reg[RA_W-1:0];
                end
                if (lane_stat.valid && lane_stat.hit)
                begin
                    // Drop the read in flight and mark the found rectangle
                    rd_pend_next = 1'b0;
                    ptr_next     = found_row;
                    end_next     = RN_W'(int'(found_row) + int'(req_reg.rect_height));
                    lo_next      = CN_W'(lane_col);
                    hi_next      = CN_W'(int'(lane_col) + int'(req_reg.rect_width));
                    pc_next      = lane_col;
                    pr_next      = found_row[RA_W-1:0];
                    state_next   = S_MARK;
                end
                else if (lane_stat.valid && (int'(lane_tag) + 1 == int'(rows)))
                begin
                    rd_pend_next = 1'b0;
                    finish       = 1'b1;
                end
            end
            S_MARK:
            begin
                ram_we = rd_pend_reg;
                if (ptr_reg < end_reg)
                begin
                    ram_re       = 1'b1;
                    ptr_next     = ptr_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr_next = ptr_reg[RA_W-1:0];
                end
                else if (!rd_pend_reg)
                begin
                    finish = 1'b1;
                    fin_ok = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Build the result beat
        done_next  = finish;
        rsp_next   = rsp_reg;
        count_next = count_reg;
        if (finish)
        begin
            state_next             = S_IDLE;
            rsp_next.success       = fin_ok;
            rsp_next.place_col     = tra_pkg::POS_W'(pc_next);
            rsp_next.place_row     = tra_pkg::POS_W'(pr_next);
            if (fin_ok || (req_reg.cmd == tra_pkg::CMD_FREE))
            begin
                count_next = count_upd;
            end
            rsp_next.tiles_in_use  = count_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            count_reg   <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        rd_addr_reg <= rd_addr_next;
        pc_reg      <= pc_next;
        pr_reg      <= pr_next;
        rsp_reg     <= rsp_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= tra_pkg::GRID_COLS_RST;
            grid_rows_reg <= tra_pkg::GRID_ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tra_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                tra_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                default:                grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // Per-row valid flags: set on first write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                row_vld_reg[r] <= 1'b0;
            end
        end
        else if (ram_we)
        begin
            row_vld_reg[ram_waddr] <= 1'b1;
        end
    end

    tra_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tra_lanes #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_lanes (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (lane_ctrl),
        .row_bits    (row_eff),
        .row_tag     (rd_addr_reg),
        .rect_width  (req_reg.rect_width),
        .rect_height (req_reg.rect_height),
        .cols        (cols),
        .stat        (lane_stat),
        .hit_col     (lane_col),
        .hit_tag     (lane_tag)
    );

    // Read-modify-write never reads the row being written back
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("occupancy read and write hit the same row");

    // Occupancy changes only while marking or clearing
    a_write_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_MARK))
        else $error("occupancy write outside marking");

    // A result beat always closes a started item
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE))
        else $error("result beat without an item in work");

    // A granted rectangle lies inside the grid
    a_place_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.success && (req_reg.cmd == tra_pkg::CMD_ALLOC))
        |-> ((int'(pr_reg) + int'(req_reg.rect_height) <= int'(rows))
             && (int'(pc_reg) + int'(req_reg.rect_width) <= int'(cols))))
        else $error("granted rectangle exceeds the grid");

    // The held request stays put while the block works
    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && (state_next != S_IDLE)) |=> $stable(req_reg))
        else $error("request changed during work");

endmodule

/* rtl/core/tra_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tra_lanes.sv */
// Column lanes of the allocator: per-column vertical free-run counters, a
// registered fit vector and a first-fit column encoder.
// Depends on tra_pkg.
module tra_lanes #(
    parameter int MAX_COLS = tra_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tra_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tra_pkg::lane_ctrl_t                 ctrl,
    input  logic [MAX_COLS-1:0]                 row_bits,
    input  logic [$clog2(MAX_ROWS)-1:0]         row_tag,
    input  logic [tra_pkg::DIM_W-1:0]           rect_width,
    input  logic [tra_pkg::DIM_W-1:0]           rect_height,
    input  logic [$clog2(MAX_COLS+1)-1:0]       cols,
    output tra_pkg::lane_stat_t                 stat,
    output logic [$clog2(MAX_COLS)-1:0]         hit_col,
    output logic [$clog2(MAX_ROWS)-1:0]         hit_tag
);

    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int CA_W = $clog2(MAX_COLS);

    logic [tra_pkg::DIM_W-1:0] vrun_reg [MAX_COLS];
    logic                      s1_vld_reg;
    logic [RA_W-1:0]           s1_tag_reg;
    logic [MAX_COLS-1:0]       fit_reg;
    logic [MAX_COLS-1:0]       fit_next;
    logic                      s2_vld_reg;
    logic [RA_W-1:0]           s2_tag_reg;
    logic [MAX_COLS-1:0]       col_ok;
    logic [MAX_COLS-1:0]       width_mask;
    logic [CA_W-1:0]           first_col;

    // Count free rows per column, saturating at the rectangle height
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                vrun_reg[c] <= '0;
            end
            s1_vld_reg <= 1'b0;
            s1_tag_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                vrun_reg[c] <= '0;
            end
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctrl.load;
            if (ctrl.load)
            begin
                s1_tag_reg <= row_tag;
                for (int c = 0; c < MAX_COLS; c++)
                begin
                    if (row_bits[c])
                    begin
                        vrun_reg[c] <= '0;
                    end
                    else if (vrun_reg[c] < rect_height)
                    begin
                        vrun_reg[c] <= vrun_reg[c] + 1'b1;
                    end
                end
            end
        end
    end

    // Find every column where a width-wide window of clear columns starts
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_ok[c]     = (vrun_reg[c] >= rect_height);
            width_mask[c] = (c < int'(rect_width));
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            fit_next[c] = (((~col_ok) >> c) & width_mask) == '0
                          && (c + int'(rect_width) <= int'(cols));
        end
    end

    // Hold the fit vector for the encoder stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s2_tag_reg <= '0;
            fit_reg    <= '0;
        end
        else if (ctrl.clear)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
            if (s1_vld_reg)
            begin
                s2_tag_reg <= s1_tag_reg;
                fit_reg    <= fit_next;
            end
        end
    end

    // Pick the lowest fitting column
    always_comb
    begin
        first_col = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--)
        begin
            if (fit_reg[c])
            begin
                first_col = CA_W'(c);
            end
        end
    end

    assign stat.valid = s2_vld_reg;
    assign stat.hit   = |fit_reg;
    assign hit_col    = first_col;
    assign hit_tag    = s2_tag_reg;

endmodule

/* tb/tile_rectangle_first_fit_allocator_tb.sv */
// Self-checking testbench for the tile rectangle first-fit allocator.
// Drives allocate/free beats and grid settings, and predicts each result beat.
// Depends on tra_pkg and the tile_rectangle_first_fit_allocator RTL.
module tile_rectangle_first_fit_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_COLS_MAX = tra_pkg::MAX_COLS_DEF;
    localparam int GRID_ROWS_MAX = tra_pkg::MAX_ROWS_DEF;
    localparam int SETTLE_CYCLES = 2 * GRID_ROWS_MAX + 2 * 32 + 16;
    localparam int CYCLE_LIMIT   = 600000;

    // Tracks grid occupancy and the tile count, and checks result beats in order
    class placement_checker;
        int                    grid_cols;
        int                    grid_rows;
        logic [31:0]           occupancy [GRID_ROWS_MAX];
        int                    tiles_used;
        tra_pkg::rsp_t         expected_placements [$];
        int                    errors;
        int                    placed;
        int                    missed;
        int                    freed;

        function new();
            grid_cols  = int'(tra_pkg::GRID_COLS_RST);
            grid_rows  = int'(tra_pkg::GRID_ROWS_RST);
            tiles_used = 0;
            errors     = 0;
            placed     = 0;
            missed     = 0;
            freed      = 0;
            foreach (occupancy[i]) occupancy[i] = '0;
        endfunction

        function void set_reg(tra_pkg::reg_idx_t idx, logic [tra_pkg::DIM_W-1:0] value);
            case (idx)
                tra_pkg::REG_GRID_COLS: grid_cols = int'(value);
                tra_pkg::REG_GRID_ROWS: grid_rows = int'(value);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_placements.size();
        endfunction

        // Apply one accepted request to the shadow grid and queue its result
        function tra_pkg::rsp_t note_request(tra_pkg::req_t r);
            int            cols;
            int            rows;
            int            w;
            int            h;
            int            fc;
            int            fr;
            int            area;
            int            ce;
            int            re;
            logic [63:0]   m;
            bit            found;
            bit            clash;
            tra_pkg::rsp_t res;
            cols  = (grid_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : grid_cols;
            rows  = (grid_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : grid_rows;
            w     = int'(r.rect_width);
            h     = int'(r.rect_height);
            fc    = int'(r.free_col);
            fr    = int'(r.free_row);
            area  = w * h;
            res   = '0;
            found = 1'b0;
            if (r.cmd == tra_pkg::CMD_ALLOC)
            begin
                if (w != 0 && h != 0 && w <= cols && h <= rows)
                begin
                    // Rows outer, columns inner, take the first free spot
                    for (int y = 0; y + h <= rows && !found; y++)
                    begin
                        for (int x = 0; x + w <= cols && !found; x++)
                        begin
                            m     = ((64'd1 << w) - 64'd1) << x;
                            clash = 1'b0;
                            for (int k = 0; k < h; k++)
                            begin
                                if ((occupancy[y + k] & m[31:0]) != '0)
                                    clash = 1'b1;
                            end
                            if (!clash)
                            begin
                                for (int k = 0; k < h; k++)
                                    occupancy[y + k] |= m[31:0];
                                found         = 1'b1;
                                res.place_col = tra_pkg::POS_W'(x);
                                res.place_row = tra_pkg::POS_W'(y);
                            end
                        end
                    end
                end
                if (found)
                begin
                    res.success = 1'b1;
                    tiles_used  = tiles_used + area;
                    if (tiles_used > int'(tra_pkg::COUNT_MAX))
                        tiles_used = int'(tra_pkg::COUNT_MAX);
                    placed++;
                end
                else
                begin
                    missed++;
                end
            end
            else
            begin
                // Clear only the part inside the grid, subtract the full area
                res.success = 1'b1;
                if (w != 0 && h != 0 && fc < cols && fr < rows)
                begin
                    ce = (fc + w > cols) ? cols : fc + w;
                    re = (fr + h > rows) ? rows : fr + h;
                    m  = ((64'd1 << (ce - fc)) - 64'd1) << fc;
                    for (int y = fr; y < re; y++)
                        occupancy[y] &= ~m[31:0];
                end
                tiles_used = (tiles_used > area) ? tiles_used - area : 0;
                freed++;
            end
            res.tiles_in_use    = tra_pkg::COUNT_W'(tiles_used);
            expected_placements = {expected_placements, res};
            return res;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Match one result beat against the oldest prediction
        function void check_result(tra_pkg::rsp_t got);
            tra_pkg::rsp_t want;
            if (expected_placements.size() == 0)
            begin
                $error("result beat with no request outstanding: %h", got);
                errors++;
            end
            else
            begin
                want = expected_placements.pop_front();
                compare_field("success", int'(want.success), int'(got.success));
                compare_field("place_col", int'(want.place_col), int'(got.place_col));
                compare_field("place_row", int'(want.place_row), int'(got.place_row));
                compare_field("tiles_in_use", int'(want.tiles_in_use),
                              int'(got.tiles_in_use));
            end
        endfunction

        function void check_leftover();
            if (expected_placements.size() != 0)
            begin
                $error("%0d result beats never arrived", expected_placements.size());
                errors++;
            end
        endfunction
    endclass

    typedef struct {
        int col;
        int row;
        int w;
        int h;
    } rect_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    tra_pkg::req_t             req;
    logic                      done;
    tra_pkg::rsp_t             rsp;
    logic                      cfg_we;
    tra_pkg::reg_idx_t         cfg_idx;
    logic [tra_pkg::DIM_W-1:0] cfg_wdata;

    placement_checker sb;
    rect_t            live_rects [$];
    int               sender_idle_pct;
    int               sent;
    int               settings_seen;
    int               cycles;

    tile_rectangle_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Check every result beat at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** tile_rectangle_first_fit_allocator: FAILED **");
            $finish;
        end
    end

    function tra_pkg::req_t mk(tra_pkg::cmd_t cmd, int w, int h, int c, int r);
        tra_pkg::req_t it;
        it.cmd         = cmd;
        it.rect_width  = tra_pkg::DIM_W'(w);
        it.rect_height = tra_pkg::DIM_W'(h);
        it.free_col    = tra_pkg::POS_W'(c);
        it.free_row    = tra_pkg::POS_W'(r);
        return it;
    endfunction

    // Mostly small sides, sometimes grid-sized, sometimes anything the field holds
    function int rand_side();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return $urandom_range(1, 4);
        else if (sel < 9)
            return $urandom_range(1, 32);
        return $urandom_range(63);
    endfunction

    // Allocate, free a live rectangle, or free a random one as noise
    function tra_pkg::req_t next_random_request();
        int            pick;
        int            idx;
        rect_t         rc;
        tra_pkg::req_t it;
        pick = $urandom_range(99);
        it   = mk(tra_pkg::CMD_ALLOC, rand_side(), rand_side(),
                  $urandom_range(31), $urandom_range(31));
        if (pick >= 55)
        begin
            if (pick < 90 && live_rects.size() != 0)
            begin
                idx = $urandom_range(live_rects.size() - 1);
                rc  = live_rects[idx];
                live_rects.delete(idx);
                it  = mk(tra_pkg::CMD_FREE, rc.w, rc.h, rc.col, rc.row);
            end
            else
            begin
                it.cmd = tra_pkg::CMD_FREE;
            end
        end
        return it;
    endfunction

    // Hold start until the block takes the beat, with random sender gaps
    task automatic send_item(input tra_pkg::req_t item);
        tra_pkg::rsp_t predicted;
        rect_t         rc;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        do @(posedge clk); while (busy);
        predicted = sb.note_request(item);
        sent++;
        if (item.cmd == tra_pkg::CMD_ALLOC && predicted.success)
        begin
            rc.col     = int'(predicted.place_col);
            rc.row     = int'(predicted.place_row);
            rc.w       = int'(item.rect_width);
            rc.h       = int'(item.rect_height);
            live_rects = {live_rects, rc};
        end
    endtask

    // Drop start and wait for all results and the block to go quiet
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(input logic [tra_pkg::DIM_W-1:0] cols,
                              input logic [tra_pkg::DIM_W-1:0] rows);
        cfg_we    <= 1'b1;
        cfg_idx   <= tra_pkg::REG_GRID_COLS;
        cfg_wdata <= cols;
        @(posedge clk);
        sb.set_reg(tra_pkg::REG_GRID_COLS, cols);
        cfg_idx   <= tra_pkg::REG_GRID_ROWS;
        cfg_wdata <= rows;
        @(posedge clk);
        sb.set_reg(tra_pkg::REG_GRID_ROWS, rows);
        cfg_we    <= 1'b0;
        settings_seen++;
    endtask

    task automatic run_phase(input logic [tra_pkg::DIM_W-1:0] cols,
                             input logic [tra_pkg::DIM_W-1:0] rows,
                             input int idle_pct, input int count);
        wait_idle();
        write_grid(cols, rows);
        sender_idle_pct = idle_pct;
        repeat (count) send_item(next_random_request());
    endtask

    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        sent            = 0;
        settings_seen   = 0;
        cycles          = 0;
        rst_n           <= 1'b0;
        start           <= 1'b0;
        req             <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= tra_pkg::REG_GRID_COLS;
        cfg_wdata       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on the reset grid
        send_item(mk(tra_pkg::CMD_ALLOC, 32, 32, 31, 31));  // whole grid
        send_item(mk(tra_pkg::CMD_ALLOC, 1, 1, 0, 0));      // no space left
        send_item(mk(tra_pkg::CMD_FREE, 32, 32, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 0, 5, 0, 0));      // empty rectangle
        send_item(mk(tra_pkg::CMD_ALLOC, 5, 0, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 33, 1, 0, 0));     // wider than the grid
        send_item(mk(tra_pkg::CMD_ALLOC, 1, 63, 0, 0));     // taller than the grid
        send_item(mk(tra_pkg::CMD_ALLOC, 3, 2, 21, 10));
        send_item(mk(tra_pkg::CMD_ALLOC, 4, 4, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 32, 1, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 2, 3, 0, 0));
        send_item(mk(tra_pkg::CMD_FREE, 0, 3, 0, 0));       // empty free
        send_item(mk(tra_pkg::CMD_FREE, 3, 0, 1, 1));
        send_item(mk(tra_pkg::CMD_ALLOC, 1, 1, 0, 0));
        send_item(mk(tra_pkg::CMD_FREE, 5, 5, 30, 31));     // partly outside the grid
        send_item(mk(tra_pkg::CMD_ALLOC, 31, 31, 0, 0));
        send_item(mk(tra_pkg::CMD_FREE, 63, 63, 31, 31));   // count underflow
        send_item(mk(tra_pkg::CMD_ALLOC, 1, 1, 0, 0));
        send_item(mk(tra_pkg::CMD_FREE, 32, 32, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 32, 1, 0, 0));
        send_item(mk(tra_pkg::CMD_ALLOC, 1, 31, 0, 0));
        send_item(mk(tra_pkg::CMD_FREE, 63, 63, 0, 0));

        // Random phases across grid settings and sender gap rates
        run_phase(6'd63, 6'd63, 0, 150);
        run_phase(6'd8, 6'd6, 58, 130);
        run_phase(6'd1, 6'd1, 0, 60);
        run_phase(6'd0, 6'd32, 23, 40);
        run_phase(6'd32, 6'd0, 0, 40);
        run_phase(6'd32, 6'd32, 58, 180);
        run_phase(6'd5, 6'd32, 23, 130);
        run_phase(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)), 0, 130);
        run_phase(6'd12, 6'd40, 23, 150);
        run_phase(6'd32, 6'd32, 58, 140);

        wait_idle();
        sb.check_leftover();
        $display("Sent %0d requests over %0d grid settings: %0d placed, %0d missed, %0d freed.",
                 sent, settings_seen, sb.placed, sb.missed, sb.freed);
        if (sb.errors == 0)
            $display("** tile_rectangle_first_fit_allocator: PASSED **");
        else
            $display("** tile_rectangle_first_fit_allocator: FAILED **");
        $finish;
    end

endmodule
